// ----- rtl/core/vfsq_pkg.sv -----
package vfsq_pkg;

  localparam int CW = 15;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_STATE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] MODE_CLOSEST = 2'd0;
  localparam logic [1:0] MODE_UNDER   = 2'd1;
  localparam logic [1:0] MODE_ABOVE   = 2'd2;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic   valid;
    logic   off;
    coord_t y2;
    coord_t x2;
    coord_t y1;
    coord_t x1;
  } entry_t;

  typedef struct packed {
    coord_t      px;
    coord_t      py;
    logic [14:0] range_above;
    logic [14:0] range_under;
    logic [1:0]  mode;
  } qry_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] new_y;
    logic               from_under;
  } res_t;

endpackage

// ----- rtl/core/vertical_floor_segment_query.sv -----
// Writes store the segment when taken; state requests write back the off bit of a
// valid entry in ST_RMW; unknown kinds are dropped. A query reads one entry per cycle,
// then the 19-stage multiply/divide pipeline and the window update drain.
// One request is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset; after it the table is cleared one entry per cycle,
// and no request is taken until every entry is cleared.
module vertical_floor_segment_query #(
  parameter int SEGMENTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_index,
  input  vfsq_pkg::coord_t   in_seg_x1,
  input  vfsq_pkg::coord_t   in_seg_y1,
  input  vfsq_pkg::coord_t   in_seg_x2,
  input  vfsq_pkg::coord_t   in_seg_y2,
  input  logic               in_off_flag,
  input  vfsq_pkg::coord_t   in_point_x,
  input  vfsq_pkg::coord_t   in_point_y,
  input  logic [14:0]        in_range_above,
  input  logic [14:0]        in_range_under,
  input  logic [1:0]         in_find_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [15:0] out_new_y,
  output logic               out_from_under
);
  import vfsq_pkg::*;

  localparam int AW = $clog2(SEGMENTS);
  localparam logic [AW-1:0] LAST = AW'(SEGMENTS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RMW   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r;
  logic          off_r;
  logic          scan_rd_r;
  qry_t          qry_r;
  qry_t          qry_in;
  res_t          res, out_r;
  logic          out_valid_r;

  logic          acc;
  logic [16:0]   idx_w;
  logic          idx_ok;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          busy, start, load;

  assign acc    = in_valid & in_ready;
  assign idx_w  = 17'(in_index);
  assign idx_ok = idx_w < 17'(SEGMENTS);
  assign start  = acc && in_kind == KIND_QUERY;
  assign load   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE);

  assign qry_in = '{px: in_point_x, py: in_point_y, range_above: in_range_above,
                    range_under: in_range_under, mode: in_find_mode};

  // Memory port steering: clear sweep, segment load, or off-bit write back; reads for scan and state requests.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = '0;
    re    = 1'b0;
    raddr = cnt_r;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_r == ST_RMW) begin
      we        = rdata.valid;
      waddr     = idx_r;
      wdata     = rdata;
      wdata.off = off_r;
    end else if (acc && in_kind == KIND_WRITE && idx_ok) begin
      we    = 1'b1;
      waddr = idx_w[AW-1:0];
      wdata = '{valid: 1'b1, off: 1'b0, y2: in_seg_y2, x2: in_seg_x2,
                y1: in_seg_y1, x1: in_seg_x1};
    end
    if (state_r == ST_SCAN) begin
      re = 1'b1;
    end else if (acc && in_kind == KIND_STATE) begin
      re    = 1'b1;
      raddr = idx_w[AW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc && in_kind == KIND_STATE && idx_ok) begin
          state_nxt = ST_RMW;
        end else if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RMW: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!scan_rd_r && !busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      scan_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      scan_rd_r <= (state_r == ST_SCAN);
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request fields for the length of the work, and capture the result for output.
  always_ff @(posedge clk) begin
    if (acc) begin
      idx_r <= idx_w[AW-1:0];
      off_r <= in_off_flag;
    end
    if (start) begin
      qry_r <= qry_in;
    end
    if (load) begin
      out_r <= res;
    end
  end

  vfsq_mem #(
    .DEPTH (SEGMENTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  vfsq_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .rd_vld  (scan_rd_r),
    .rd_data (rdata),
    .qry     (start ? qry_in : qry_r),
    .busy    (busy),
    .res     (res)
  );

  assign out_valid      = out_valid_r;
  assign out_found      = out_r.found;
  assign out_new_y      = out_r.new_y;
  assign out_from_under = out_r.from_under;

endmodule

// ----- rtl/core/vfsq_mem.sv -----
module vfsq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  vfsq_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output vfsq_pkg::entry_t rdata
);
  import vfsq_pkg::*;

  entry_t ram [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= ram[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/vfsq_eval.sv -----
module vfsq_eval (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             rd_vld,
  input  vfsq_pkg::entry_t rd_data,
  input  vfsq_pkg::qry_t   qry,
  output logic             busy,
  output vfsq_pkg::res_t   res
);
  import vfsq_pkg::*;

  localparam int NS = 16;  // abs stage plus fifteen quotient steps

  logic elig;
  logic v1_r, v2_r, yv_r;
  logic signed [15:0] dx_r, dy_r;
  logic [14:0] den1_r, den2_r;
  coord_t y11_r, y12_r;
  logic signed [31:0] prod_r;
  logic [NS-1:0] vd_r;
  logic [NS-1:0] neg_r;
  logic [14:0] den_d_r [NS];
  coord_t      y1_d_r  [NS];
  logic [14:0] rem_r   [NS];
  logic [14:0] lq_r    [NS];
  logic [14:0] rem_nxt [NS];
  logic [14:0] lq_nxt  [NS];
  logic [31:0] mag;
  logic signed [16:0] qs, yat_nxt, yat_r;
  logic signed [16:0] py17, lim_a_r, lim_u_r;
  logic have_a_r, have_u_r;
  logic signed [16:0] gap_a, gap_u;
  logic pick, pick_under;

  // Segment is valid, not off, spans the query x and runs left to right.
  always_comb begin
    elig = rd_vld && rd_data.valid && !rd_data.off && (rd_data.x1 < rd_data.x2) &&
           (rd_data.x1 <= qry.px) && (qry.px <= rd_data.x2);
  end

  assign mag = prod_r[31] ? 32'(-prod_r) : 32'(prod_r);

  // Stage 0 loads the magnitude; one restoring step per later stage; quotient bits shift in as dividend bits leave.
  always_comb begin
    logic [15:0] t;
    rem_nxt[0] = mag[29:15];
    lq_nxt[0]  = mag[14:0];
    for (int k = 1; k < NS; k++) begin
      t = {rem_r[k-1], lq_r[k-1][14]};
      if (t >= {1'b0, den_d_r[k-1]}) begin
        rem_nxt[k] = 15'(t - {1'b0, den_d_r[k-1]});
        lq_nxt[k]  = {lq_r[k-1][13:0], 1'b1};
      end else begin
        rem_nxt[k] = t[14:0];
        lq_nxt[k]  = {lq_r[k-1][13:0], 1'b0};
      end
    end
  end

  always_comb begin
    qs = neg_r[NS-1] ? -$signed({2'b00, lq_r[NS-1]}) : $signed({2'b00, lq_r[NS-1]});
    yat_nxt = qs + {{2{y1_d_r[NS-1][14]}}, y1_d_r[NS-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vd_r <= '0;
      yv_r <= 1'b0;
    end else begin
      v1_r <= elig;
      v2_r <= v1_r;
      vd_r <= {vd_r[NS-2:0], v2_r};
      yv_r <= vd_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= {qry.px[14], qry.px} - {rd_data.x1[14], rd_data.x1};
    dy_r   <= {rd_data.y2[14], rd_data.y2} - {rd_data.y1[14], rd_data.y1};
    den1_r <= 15'({rd_data.x2[14], rd_data.x2} - {rd_data.x1[14], rd_data.x1});
    y11_r  <= rd_data.y1;
    prod_r <= dy_r * dx_r;
    den2_r <= den1_r;
    y12_r  <= y11_r;
    neg_r[0]   <= prod_r[31];
    den_d_r[0] <= den2_r;
    y1_d_r[0]  <= y12_r;
    rem_r[0]   <= rem_nxt[0];
    lq_r[0]    <= lq_nxt[0];
    for (int k = 1; k < NS; k++) begin
      neg_r[k]   <= neg_r[k-1];
      den_d_r[k] <= den_d_r[k-1];
      y1_d_r[k]  <= y1_d_r[k-1];
      rem_r[k]   <= rem_nxt[k];
      lq_r[k]    <= lq_nxt[k];
    end
    yat_r <= yat_nxt;
  end

  assign py17 = {{2{qry.py[14]}}, qry.py};

  // Tighten the search window as hits arrive.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_a_r <= 1'b0;
      have_u_r <= 1'b0;
    end else if (start) begin
      have_a_r <= 1'b0;
      have_u_r <= 1'b0;
    end else if (yv_r) begin
      if (yat_r <= py17 && yat_r > lim_a_r) have_a_r <= 1'b1;
      if (yat_r >= py17 && yat_r < lim_u_r) have_u_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lim_a_r <= py17 - $signed({2'b00, qry.range_above});
      lim_u_r <= py17 + $signed({2'b00, qry.range_under});
    end else if (yv_r) begin
      if (yat_r <= py17 && yat_r > lim_a_r) lim_a_r <= yat_r;
      if (yat_r >= py17 && yat_r < lim_u_r) lim_u_r <= yat_r;
    end
  end

  assign gap_a = py17 - lim_a_r;
  assign gap_u = lim_u_r - py17;

  always_comb begin
    pick       = 1'b0;
    pick_under = 1'b0;
    unique case (qry.mode)
      MODE_CLOSEST: begin
        pick       = have_a_r | have_u_r;
        pick_under = have_u_r && !(have_a_r && gap_a < gap_u);
      end
      MODE_UNDER: begin
        pick       = have_a_r | have_u_r;
        pick_under = have_u_r;
      end
      MODE_ABOVE: begin
        pick       = have_a_r | have_u_r;
        pick_under = !have_a_r;
      end
      default: begin
        pick       = 1'b0;
        pick_under = 1'b0;
      end
    endcase
    res.found      = pick;
    res.from_under = pick & pick_under;
    if (pick) begin
      res.new_y = 16'((pick_under ? lim_u_r : lim_a_r) - 17'sd1);
    end else begin
      res.new_y = {qry.py[14], qry.py};
    end
  end

  assign busy = v1_r | v2_r | (|vd_r) | yv_r;

endmodule
